// ----- src/pwl_pkg.sv -----
// shared types and constants for the breakpoint table interpolator
// no dependencies; imported by every module of the block except pwl_ram
package pwl_pkg;

  localparam int DataW   = 32;
  localparam int CountW  = 5;
  localparam int TolW    = 16;
  localparam int CfgIdxW = 1;
  localparam int CfgW    = 16;

  // request command codes
  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_POINT_COUNT = 1'b0;
  localparam logic [CfgIdxW-1:0] CFG_MATCH_TOL   = 1'b1;

  typedef enum logic [2:0] {
    RS_WRITE    = 3'd0,
    RS_MATCH    = 3'd1,
    RS_INTERP   = 3'd2,
    RS_SAT      = 3'd3,
    RS_NONMONO  = 3'd4
  } res_status_t;

  typedef enum logic [2:0] {
    LS_ZERO,
    LS_MATCH,
    LS_FIRST,
    LS_LAST,
    LS_INTERP
  } lsel_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_WRITE,
    S_SCAN,
    S_DRAIN,
    S_DECIDE,
    S_PREP,
    S_MUL,
    S_DIV,
    S_WAIT
  } state_t;

  typedef struct packed {
    logic        take;
    logic        wr;
    logic        scan_clr;
    logic        scan_rd;
    logic        prep;
    logic        mul;
    logic        div_start;
    logic        emit;
    lsel_t       lsel;
    res_status_t code;
  } dp_cmd_t;

  typedef struct packed {
    logic scan_last;
    logic nonmono;
    logic match;
    logic below;
    logic above;
    logic brk;
    logic div_done;
  } dp_stat_t;

endpackage

// ----- src/pwl_ram.sv -----
// generic single write port ram with registered read
// no dependencies
module pwl_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- src/pwl_div.sv -----
// restoring divider, one quotient bit per cycle, 64 by 32 bits
// depends on pwl_pkg; numerator high word must be below the divisor
module pwl_div import pwl_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [DataW-1:0] num_hi,
  input  logic [DataW-1:0] num_lo,
  input  logic [DataW-1:0] den,
  output logic [DataW-1:0] quo,
  output logic             done
);

  localparam int StepW = $clog2(DataW);

  logic             active;
  logic [StepW-1:0] step_cnt;
  logic [DataW-1:0] rem;
  logic [DataW-1:0] qsh;
  logic [DataW+1:0] trial;
  logic             ge;

  assign trial = {1'b0, rem, qsh[DataW-1]} - {2'b00, den};
  assign ge    = ~trial[DataW+1];
  assign quo   = qsh;

  always_ff @(posedge clk) begin
    if (rst) begin
      active   <= 1'b0;
      done     <= 1'b0;
      step_cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        active   <= 1'b1;
        step_cnt <= '0;
      end else if (active) begin
        step_cnt <= step_cnt + 1'b1;
        if (step_cnt == StepW'(DataW - 1)) begin
          active <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end

  // remainder stays below the divisor, so it fits one word
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= num_hi;
      qsh <= num_lo;
    end else if (active) begin
      rem <= ge ? trial[DataW-1:0] : {rem[DataW-2:0], qsh[DataW-1]};
      qsh <= {qsh[DataW-2:0], ge};
    end
  end

endmodule

// ----- src/pwl_ctrl.sv -----
// controller state machine: sequences write, table scan, decision, multiply and divide
// depends on pwl_pkg; drives the datapath through dp_cmd_t, reads dp_stat_t
module pwl_ctrl import pwl_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  input  logic     cmd,
  output logic     busy,
  output dp_cmd_t  ctl,
  input  dp_stat_t sts
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign busy = (state != S_IDLE);

  always_comb begin
    ctl        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          ctl.take     = 1'b1;
          ctl.scan_clr = 1'b1;
          state_next   = (cmd == CMD_WRITE) ? S_WRITE : S_SCAN;
        end
      end
      S_WRITE: begin
        ctl.wr     = 1'b1;
        ctl.emit   = 1'b1;
        ctl.lsel   = LS_ZERO;
        ctl.code   = RS_WRITE;
        state_next = S_IDLE;
      end
      S_SCAN: begin
        ctl.scan_rd = 1'b1;
        if (sts.scan_last) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_next = S_DECIDE;
      end
      S_DECIDE: begin
        priority if (sts.nonmono) begin
          ctl.emit   = 1'b1;
          ctl.lsel   = LS_ZERO;
          ctl.code   = RS_NONMONO;
          state_next = S_IDLE;
        end else if (sts.match) begin
          ctl.emit   = 1'b1;
          ctl.lsel   = LS_MATCH;
          ctl.code   = RS_MATCH;
          state_next = S_IDLE;
        end else if (sts.below) begin
          ctl.emit   = 1'b1;
          ctl.lsel   = LS_FIRST;
          ctl.code   = RS_SAT;
          state_next = S_IDLE;
        end else if (sts.above || !sts.brk) begin
          ctl.emit   = 1'b1;
          ctl.lsel   = LS_LAST;
          ctl.code   = RS_SAT;
          state_next = S_IDLE;
        end else begin
          state_next = S_PREP;
        end
      end
      S_PREP: begin
        ctl.prep   = 1'b1;
        state_next = S_MUL;
      end
      S_MUL: begin
        ctl.mul    = 1'b1;
        state_next = S_DIV;
      end
      S_DIV: begin
        ctl.div_start = 1'b1;
        state_next    = S_WAIT;
      end
      S_WAIT: begin
        if (sts.div_done) begin
          ctl.emit   = 1'b1;
          ctl.lsel   = LS_INTERP;
          ctl.code   = RS_INTERP;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ----- src/pwl_dp.sv -----
// datapath: config registers, time and load tables, scan logic, multiply,
// divider and result register; depends on pwl_pkg, pwl_ram, pwl_div
module pwl_dp import pwl_pkg::*; #(
  parameter int MAX_POINTS = 16
) (
  input  logic                     clk,
  input  logic                     rst,
  input  dp_cmd_t                  ctl,
  output dp_stat_t                 sts,
  input  logic [3:0]               entry_index,
  input  logic [DataW-1:0]         entry_time,
  input  logic signed [DataW-1:0]  entry_load,
  input  logic [DataW-1:0]         query_time,
  input  logic                     cfg_valid,
  input  logic [CfgIdxW-1:0]       cfg_index,
  input  logic [CfgW-1:0]          cfg_data,
  output logic                     result_strobe,
  output logic signed [DataW-1:0]  load_value,
  output logic [2:0]               status
);

  localparam int IdxW = $clog2(MAX_POINTS);

  logic [CountW-1:0] point_count;
  logic [TolW-1:0]   match_tol;

  logic [3:0]       idx_q;
  logic [DataW-1:0] etime_q;
  logic [DataW-1:0] eload_q;
  logic [DataW-1:0] q_t;

  logic [31:0]      pc_ext;
  logic [31:0]      n_eff;
  logic [31:0]      n_last_w;
  logic [IdxW-1:0]  n_last;
  logic             wr_ok;

  logic [IdxW-1:0]  rd_addr;
  logic             rd_pend;
  logic [IdxW-1:0]  proc_idx;
  logic [DataW-1:0] t_rd;
  logic [DataW-1:0] l_rd;

  logic [DataW-1:0] prev_t, prev_l;
  logic [DataW-1:0] t_first, l_first, t_last, l_last;
  logic [DataW-1:0] match_l;
  logic [DataW-1:0] bt0, bl0, bt1, bl1;
  logic             nonmono, match_f, brk;

  logic [DataW-1:0] diff;
  logic             hit;
  logic             bhit;

  logic [DataW:0]     dl;
  logic [DataW:0]     dl_neg;
  logic               neg_q;
  logic [DataW-1:0]   mag_q, dq_q, dt_q;
  logic [2*DataW-1:0] prod;
  logic [DataW-1:0]   quo;
  logic               div_done;
  logic [DataW-1:0]   interp;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      point_count <= CountW'(2);
      match_tol   <= TolW'(1);
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_POINT_COUNT: point_count <= cfg_data[CountW-1:0];
        CFG_MATCH_TOL:   match_tol   <= cfg_data[TolW-1:0];
        default: ;
      endcase
    end
  end

  // request fields
  always_ff @(posedge clk) begin
    if (ctl.take) begin
      idx_q   <= entry_index;
      etime_q <= entry_time;
      eload_q <= entry_load;
      q_t     <= query_time;
    end
  end

  // used entry count clamped to two .. MAX_POINTS
  always_comb begin
    pc_ext = 32'(point_count);
    priority if (pc_ext < 32'd2) begin
      n_eff = 32'd2;
    end else if (pc_ext > 32'(MAX_POINTS)) begin
      n_eff = 32'(MAX_POINTS);
    end else begin
      n_eff = pc_ext;
    end
    n_last_w = n_eff - 32'd1;
    n_last   = n_last_w[IdxW-1:0];
  end

  assign wr_ok = (32'(idx_q) < 32'(MAX_POINTS));

  pwl_ram #(.WIDTH(DataW), .DEPTH(MAX_POINTS)) u_time_ram (
    .clk   (clk),
    .we    (ctl.wr & wr_ok),
    .waddr (IdxW'(idx_q)),
    .wdata (etime_q),
    .raddr (rd_addr),
    .rdata (t_rd)
  );

  pwl_ram #(.WIDTH(DataW), .DEPTH(MAX_POINTS)) u_load_ram (
    .clk   (clk),
    .we    (ctl.wr & wr_ok),
    .waddr (IdxW'(idx_q)),
    .wdata (eload_q),
    .raddr (rd_addr),
    .rdata (l_rd)
  );

  // per-entry checks on the word that just came out of the tables
  assign diff = (q_t >= t_rd) ? (q_t - t_rd) : (t_rd - q_t);
  assign hit  = (diff <= 32'(match_tol));
  assign bhit = (proc_idx != '0) && (prev_t < q_t) && (q_t < t_rd);

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_addr <= '0;
      rd_pend <= 1'b0;
      nonmono <= 1'b0;
      match_f <= 1'b0;
      brk     <= 1'b0;
    end else begin
      rd_pend <= ctl.scan_rd;
      if (ctl.scan_clr) begin
        rd_addr <= '0;
        nonmono <= 1'b0;
        match_f <= 1'b0;
        brk     <= 1'b0;
      end else begin
        if (ctl.scan_rd) begin
          rd_addr <= rd_addr + 1'b1;
        end
        if (rd_pend) begin
          if (proc_idx != '0 && prev_t > t_rd) begin
            nonmono <= 1'b1;
          end
          if (hit) begin
            match_f <= 1'b1;
          end
          if (bhit) begin
            brk <= 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.scan_rd) begin
      proc_idx <= rd_addr;
    end
    if (rd_pend) begin
      prev_t <= t_rd;
      prev_l <= l_rd;
      if (proc_idx == '0) begin
        t_first <= t_rd;
        l_first <= l_rd;
      end
      if (proc_idx == n_last) begin
        t_last <= t_rd;
        l_last <= l_rd;
      end
      // keep only the first matching and first bracketing entries
      if (hit && !match_f) begin
        match_l <= l_rd;
      end
      if (bhit && !brk) begin
        bt0 <= prev_t;
        bl0 <= prev_l;
        bt1 <= t_rd;
        bl1 <= l_rd;
      end
    end
  end

  // interpolation operands
  assign dl     = {bl1[DataW-1], bl1} - {bl0[DataW-1], bl0};
  assign dl_neg = (DataW+1)'(0) - dl;

  always_ff @(posedge clk) begin
    if (ctl.prep) begin
      neg_q <= dl[DataW];
      mag_q <= dl[DataW] ? dl_neg[DataW-1:0] : dl[DataW-1:0];
      dq_q  <= q_t - bt0;
      dt_q  <= bt1 - bt0;
    end
    if (ctl.mul) begin
      prod <= {{DataW{1'b0}}, mag_q} * {{DataW{1'b0}}, dq_q};
    end
  end

  pwl_div u_div (
    .clk    (clk),
    .rst    (rst),
    .start  (ctl.div_start),
    .num_hi (prod[2*DataW-1:DataW]),
    .num_lo (prod[DataW-1:0]),
    .den    (dt_q),
    .quo    (quo),
    .done   (div_done)
  );

  assign interp = neg_q ? (bl0 - quo) : (bl0 + quo);

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_strobe <= 1'b0;
    end else begin
      result_strobe <= ctl.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.emit) begin
      status <= ctl.code;
      unique case (ctl.lsel)
        LS_ZERO:   load_value <= '0;
        LS_MATCH:  load_value <= $signed(match_l);
        LS_FIRST:  load_value <= $signed(l_first);
        LS_LAST:   load_value <= $signed(l_last);
        LS_INTERP: load_value <= $signed(interp);
        default:   load_value <= '0;
      endcase
    end
  end

  always_comb begin
    sts.scan_last = (rd_addr == n_last);
    sts.nonmono   = nonmono;
    sts.match     = match_f;
    sts.below     = (q_t < t_first);
    sts.above     = (q_t > t_last);
    sts.brk       = brk;
    sts.div_done  = div_done;
  end

endmodule

// ----- src/piecewise_linear_table_interp_core.sv -----
// breakpoint table interpolator, top level: controller plus datapath
// write request: result strobe comes as busy goes low again
// query over n used entries: one table read per cycle, then the decision;
// interpolated results add the 32-step divider
// one request at a time; results cannot be stalled
// synchronous reset clears control and config; table contents stay undefined
module piecewise_linear_table_interp_core import pwl_pkg::*; #(
  parameter int MAX_POINTS = 16
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  output logic                     busy,
  input  logic                     cmd,
  input  logic [3:0]               entry_index,
  input  logic [DataW-1:0]         entry_time,
  input  logic signed [DataW-1:0]  entry_load,
  input  logic [DataW-1:0]         query_time,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [CfgIdxW-1:0]       cfg_index,
  input  logic [CfgW-1:0]          cfg_data,
  output logic                     result_strobe,
  output logic signed [DataW-1:0]  load_value,
  output logic [2:0]               status
);

  dp_cmd_t  ctl;
  dp_stat_t sts;

  assign cfg_ready = 1'b1;

  pwl_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .cmd   (cmd),
    .busy  (busy),
    .ctl   (ctl),
    .sts   (sts)
  );

  pwl_dp #(.MAX_POINTS(MAX_POINTS)) u_dp (
    .clk           (clk),
    .rst           (rst),
    .ctl           (ctl),
    .sts           (sts),
    .entry_index   (entry_index),
    .entry_time    (entry_time),
    .entry_load    (entry_load),
    .query_time    (query_time),
    .cfg_valid     (cfg_valid & cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .result_strobe (result_strobe),
    .load_value    (load_value),
    .status        (status)
  );

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted request did not make the block busy");

  a_single_strobe: assert property (@(posedge clk) disable iff (rst)
    result_strobe |=> !result_strobe)
    else $error("result strobe held for two cycles");

  a_done_with_result: assert property (@(posedge clk) disable iff (rst)
    ($fell(busy) && !$past(rst)) |-> result_strobe)
    else $error("block went idle without a result");

  a_interp_after_div: assert property (@(posedge clk) disable iff (rst)
    (ctl.emit && ctl.lsel == LS_INTERP) |-> sts.div_done)
    else $error("interpolated result emitted before the divide finished");

endmodule

// ----- sim/testbench.sv -----
// self-checking testbench for piecewise_linear_table_interp_core
// keeps its own copy of the breakpoint table and predicts each result, uses pwl_pkg
module testbench;
  import pwl_pkg::*;

  typedef struct packed {
    logic signed [DataW-1:0] load;
    res_status_t             code;
  } load_result_t;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    start = 1'b0;
  logic                    cmd = CMD_WRITE;
  logic [3:0]              entry_index = '0;
  logic [DataW-1:0]        entry_time = '0;
  logic signed [DataW-1:0] entry_load = '0;
  logic [DataW-1:0]        query_time = '0;
  logic                    cfg_valid = 1'b0;
  logic [CfgIdxW-1:0]      cfg_index = CFG_POINT_COUNT;
  logic [CfgW-1:0]         cfg_data = '0;
  logic                    busy;
  logic                    cfg_ready;
  logic                    result_strobe;
  logic signed [DataW-1:0] load_value;
  logic [2:0]              status;

  piecewise_linear_table_interp_core dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .cmd(cmd),
    .entry_index(entry_index), .entry_time(entry_time), .entry_load(entry_load),
    .query_time(query_time), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data), .result_strobe(result_strobe),
    .load_value(load_value), .status(status)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  initial begin
    #3000000;
    $display("[FAIL] regression broken");
    $finish;
  end

  // shadow copy of the table and registers
  logic [DataW-1:0]        tbl_time [16];
  logic signed [DataW-1:0] tbl_load [16];
  logic [CountW-1:0]       cfg_points = 5'd2;
  logic [TolW-1:0]         cfg_tol = 16'd1;

  load_result_t pending_loads [$];
  int errors = 0;
  int items_sent = 0;
  int writes_sent = 0;
  int config_writes = 0;
  int phase_no = 0;
  int idle_pct = 11;
  int code_count [8];

  function automatic int used_points();
    if (cfg_points < 2) return 2;
    if (cfg_points > 16) return 16;
    return int'(cfg_points);
  endfunction

  function automatic load_result_t eval_load(logic [DataW-1:0] q);
    load_result_t      r;
    int                n;
    int                i;
    logic [DataW-1:0]  d;
    longint            l0;
    longint            l1;
    longint            dl;
    longint unsigned   mag;
    longint unsigned   dq;
    longint unsigned   dt;
    longint unsigned   quo;
    n = used_points();
    r.load = '0;
    r.code = RS_NONMONO;
    for (i = 0; i + 1 < n; i++)
      if (tbl_time[i] > tbl_time[i+1]) return r;
    for (i = 0; i < n; i++) begin
      d = (q >= tbl_time[i]) ? q - tbl_time[i] : tbl_time[i] - q;
      if (d <= cfg_tol) begin
        r.load = tbl_load[i];
        r.code = RS_MATCH;
        return r;
      end
    end
    r.code = RS_SAT;
    if (q < tbl_time[0]) begin
      r.load = tbl_load[0];
      return r;
    end
    r.load = tbl_load[n-1];
    if (q > tbl_time[n-1]) return r;
    for (i = 0; i + 1 < n; i++) begin
      if (tbl_time[i] < q && q < tbl_time[i+1]) begin
        l0 = longint'(tbl_load[i]);
        l1 = longint'(tbl_load[i+1]);
        dl = l1 - l0;
        mag = (dl < 0) ? longint'(-dl) : longint'(dl);
        dq = longint'(q - tbl_time[i]);
        dt = longint'(tbl_time[i+1] - tbl_time[i]);
        quo = (mag * dq) / dt;
        // magnitude truncated, so the result leans toward the left load
        r.load = (dl < 0) ? DataW'(l0 - longint'(quo)) : DataW'(l0 + longint'(quo));
        r.code = RS_INTERP;
        return r;
      end
    end
    return r;
  endfunction

  task automatic send_request(input logic c, input logic [3:0] idx, input logic [DataW-1:0] t,
                              input logic [DataW-1:0] ld, input logic [DataW-1:0] q);
    load_result_t r;
    if ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < idle_pct);
    end
    start       <= 1'b1;
    cmd         <= c;
    entry_index <= idx;
    entry_time  <= t;
    entry_load  <= ld;
    query_time  <= q;
    do @(posedge clk); while (busy !== 1'b0);
    if (c == CMD_WRITE) begin
      r.load = '0;
      r.code = RS_WRITE;
      tbl_time[idx] = t;
      tbl_load[idx] = ld;
      writes_sent++;
    end else begin
      r = eval_load(q);
    end
    pending_loads.push_back(r);
    code_count[r.code]++;
    items_sent++;
  endtask

  task automatic wait_idle();
    start <= 1'b0;
    do @(posedge clk); while (pending_loads.size() != 0 || busy !== 1'b0);
  endtask

  task automatic set_register(input logic [CfgIdxW-1:0] idx, input logic [CfgW-1:0] data);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    if (idx == CFG_POINT_COUNT) cfg_points = data[CountW-1:0];
    else cfg_tol = data;
    config_writes++;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  always @(posedge clk) begin
    load_result_t want;
    if (!rst && result_strobe === 1'b1) begin
      if (pending_loads.size() == 0) begin
        $display("%0t: result with nothing pending, load_value %h status %0d",
                 $time, load_value, status);
        errors++;
      end else begin
        want = pending_loads.pop_front();
        if (load_value !== want.load) begin
          $display("%0t: load_value expected %h got %h", $time, want.load, load_value);
          errors++;
        end
        if (status !== want.code) begin
          $display("%0t: status expected %0d got %0d", $time, want.code, status);
          errors++;
        end
      end
    end
  end

  // a setting of both registers, then table rebuilds with queries around them plus some noise
  task automatic run_phase(input int pc, input int tol, input int quota);
    int               first;
    int               n;
    int               i;
    int               k;
    int               rot;
    int               slot;
    logic [CfgW-1:0]  d;
    logic [DataW-1:0] base;
    logic [DataW-1:0] step;
    logic [DataW-1:0] span;
    logic [DataW-1:0] q;
    logic [DataW-1:0] times [16];
    longint unsigned  maxstep;
    idle_pct = (phase_no < 3) ? 11 : (phase_no < 6) ? 68 : 0;
    phase_no++;
    d = CfgW'($urandom);
    d[CountW-1:0] = pc[CountW-1:0];
    set_register(CFG_POINT_COUNT, d);
    set_register(CFG_MATCH_TOL, tol[CfgW-1:0]);
    n = used_points();
    first = items_sent;
    while (items_sent - first < quota) begin
      if ($urandom_range(0, 99) < 12) begin
        if ($urandom_range(0, 1) == 0)
          send_request(CMD_WRITE, 4'($urandom), $urandom, $urandom, $urandom);
        else
          send_request(CMD_QUERY, 4'($urandom), $urandom, $urandom, $urandom);
      end else begin
        case ($urandom_range(0, 2))
          0: base = '0;
          1: base = $urandom_range(0, 4096);
          default: base = $urandom;
        endcase
        maxstep = (64'hFFFF_FFFF - longint'(base)) / (n - 1);
        times[0] = base;
        for (i = 1; i < n; i++) begin
          case ($urandom_range(0, 5))
            0: step = '0;
            1, 2: step = $urandom_range(1, 2 * cfg_tol + 3);
            default: step = $urandom_range(0, maxstep[31:0]);
          endcase
          if (step > maxstep) step = maxstep[31:0];
          times[i] = times[i-1] + step;
        end
        // now and then a broken sequence
        if ($urandom_range(0, 9) == 0) times[$urandom_range(0, n-1)] = $urandom;
        rot = $urandom_range(0, n-1);
        for (i = 0; i < n; i++) begin
          slot = (i + rot) % n;
          send_request(CMD_WRITE, 4'(slot), times[slot], $urandom, $urandom);
        end
        k = $urandom_range(2, 8);
        repeat (k) begin
          i = $urandom_range(0, n-2);
          case ($urandom_range(0, 5))
            0: q = tbl_time[i] - cfg_tol - 1 + $urandom_range(0, 2 * cfg_tol + 2);
            1: begin
              span = tbl_time[i+1] - tbl_time[i];
              q = tbl_time[i] + $urandom_range(0, span);
            end
            2: q = $urandom_range(0, tbl_time[0]);
            3: q = $urandom_range(tbl_time[n-1], 32'hFFFF_FFFF);
            4: q = tbl_time[i+1];
            default: q = $urandom;
          endcase
          send_request(CMD_QUERY, 4'($urandom), $urandom, $urandom, q);
        end
      end
    end
    wait_idle();
  endtask

  // every slot gets written so no query ever reads an empty entry
  task automatic test_fill_table();
    int i;
    for (i = 0; i < 16; i++) begin
      if (i == 0)
        send_request(CMD_WRITE, 4'(i), 32'd100, 32'h8000_0000, $urandom);
      else if (i == 1)
        send_request(CMD_WRITE, 4'(i), 32'h1100_0000, 32'h7FFF_FFFF, $urandom);
      else if (i == 15)
        send_request(CMD_WRITE, 4'(i), 32'hFFFF_FFFF, $urandom, $urandom);
      else
        send_request(CMD_WRITE, 4'(i), i * 32'h1100_0000, $urandom, $urandom);
    end
  endtask

  task automatic test_directed_queries();
    send_request(CMD_QUERY, 4'($urandom), $urandom, $urandom, 32'h0000_0000);
    send_request(CMD_QUERY, 4'($urandom), $urandom, $urandom, 32'hFFFF_FFFF);
    send_request(CMD_QUERY, 4'($urandom), $urandom, $urandom, 32'd101);
    send_request(CMD_QUERY, 4'($urandom), $urandom, $urandom, 32'h0880_0000);
  endtask

  task automatic test_broken_table();
    // second time below the first, then equal to it
    send_request(CMD_WRITE, 4'd1, 32'd50, 32'h0001_0000, $urandom);
    send_request(CMD_QUERY, 4'($urandom), $urandom, $urandom, 32'd75);
    send_request(CMD_WRITE, 4'd1, 32'd100, 32'hFFFF_0000, $urandom);
    send_request(CMD_QUERY, 4'($urandom), $urandom, $urandom, 32'd100);
  endtask

  task automatic test_count_limits();
    run_phase(0, 1, 244);
    run_phase(31, 65535, 244);
    run_phase(1, 0, 244);
    run_phase(17, 300, 244);
  endtask

  task automatic test_tolerance_extremes();
    run_phase(16, 0, 244);
    run_phase(2, 65535, 244);
  endtask

  task automatic test_mixed_settings();
    run_phase($urandom_range(2, 16), $urandom_range(0, 65535), 244);
    run_phase($urandom_range(2, 16), $urandom_range(0, 65535), 244);
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    test_fill_table();
    test_directed_queries();
    test_broken_table();
    test_count_limits();
    test_tolerance_extremes();
    test_mixed_settings();
    wait_idle();
    repeat (60) @(posedge clk);
    if (pending_loads.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, pending_loads.size());
      errors++;
    end
    $display("ran %0d requests (%0d table writes) over %0d register writes",
             items_sent, writes_sent, config_writes);
    $display("queries: %0d matched, %0d interpolated, %0d saturated, %0d non-monotonic",
             code_count[RS_MATCH], code_count[RS_INTERP], code_count[RS_SAT],
             code_count[RS_NONMONO]);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
